/* sv/cpl_pkg.sv */
// ----------------------------------------------------------------------------
// Crosshair projection locator package
// Shared widths, register indexes, defaults and the item flag type.
// ----------------------------------------------------------------------------
`default_nettype none

package cpl_pkg;

    // Field and register widths.
    localparam int PIXEL_W     = 8;
    localparam int DIM_W       = 11;
    localparam int COUNT_W     = 11;
    localparam int INDEX_W     = 10;
    localparam int REG_INDEX_W = 2;

    // Geometry register reset value and parameter defaults.
    localparam int DIM_RESET          = 1024;
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [REG_INDEX_W-1:0] REG_MARKER_COLOR = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // Classification of one pixel, handed from front to back.
    typedef struct packed {
        logic hit;
        logic first_row;
        logic first_col;
        logic frame_end;
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);

endpackage

`default_nettype wire

/* sv/cpl_front.sv */
// ----------------------------------------------------------------------------
// Crosshair projection locator front end
// Holds the configuration, tracks the raster position and classifies pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_front #(
    parameter int MAX_WIDTH  = cpl_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = cpl_pkg::MAX_HEIGHT_DEFAULT,
    localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write port.
    input  wire logic                             wr_en,
    input  wire logic [cpl_pkg::REG_INDEX_W-1:0]  wr_index,
    input  wire logic [cpl_pkg::DIM_W-1:0]        wr_data,
    // Pixel input.
    input  wire logic                             push,
    input  wire logic [cpl_pkg::PIXEL_W-1:0]      pixel,
    output logic                                  full,
    // Toward the queue.
    input  wire logic                             q_full,
    output logic                                  q_push,
    output cpl_pkg::flags_t                       q_flags,
    output logic [XW-1:0]                         q_x,
    output logic [YW-1:0]                         q_y,
    // Frame restart toward the back end.
    output logic                                  restart
);

    // Last valid index of a dimension after clamping to 1..maxv.
    function automatic int clamp_last(input logic [cpl_pkg::DIM_W-1:0] v, input int maxv);
        int d;
        d = int'(v);
        if (d == 0)
            d = 1;
        else if (d > maxv)
            d = maxv;
        return d - 1;
    endfunction

    logic [cpl_pkg::PIXEL_W-1:0] marker_reg;
    logic [XW-1:0]               col_last_reg;
    logic [YW-1:0]               row_last_reg;
    logic [XW-1:0]               x_reg;
    logic [YW-1:0]               y_reg;
    logic                        accept;
    logic                        last_col;
    logic                        last_row;

    // Handshake and classification of the incoming pixel.
    assign full     = q_full;
    assign accept   = push && !q_full;
    assign last_col = (x_reg == col_last_reg);
    assign last_row = (y_reg == row_last_reg);

    assign q_push            = accept;
    assign q_x               = x_reg;
    assign q_y               = y_reg;
    assign q_flags.hit       = (pixel == marker_reg);
    assign q_flags.first_row = (y_reg == '0);
    assign q_flags.first_col = (x_reg == '0);
    assign q_flags.frame_end = last_col && last_row;

    // A geometry write starts a new frame.
    assign restart = wr_en && ((wr_index == cpl_pkg::REG_FRAME_WIDTH) ||
                               (wr_index == cpl_pkg::REG_FRAME_HEIGHT));

    // Configuration registers and raster position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg   <= '0;
            col_last_reg <= XW'(clamp_last(cpl_pkg::DIM_W'(cpl_pkg::DIM_RESET), MAX_WIDTH));
            row_last_reg <= YW'(clamp_last(cpl_pkg::DIM_W'(cpl_pkg::DIM_RESET), MAX_HEIGHT));
            x_reg        <= '0;
            y_reg        <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cpl_pkg::REG_MARKER_COLOR:
                begin
                    marker_reg <= wr_data[cpl_pkg::PIXEL_W-1:0];
                end
                cpl_pkg::REG_FRAME_WIDTH:
                begin
                    col_last_reg <= XW'(clamp_last(wr_data, MAX_WIDTH));
                    x_reg        <= '0;
                    y_reg        <= '0;
                end
                cpl_pkg::REG_FRAME_HEIGHT:
                begin
                    row_last_reg <= YW'(clamp_last(wr_data, MAX_HEIGHT));
                    x_reg        <= '0;
                    y_reg        <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (last_col)
            begin
                x_reg <= '0;
                if (last_row)
                    y_reg <= '0;
                else
                    y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/cpl_queue.sv */
// ----------------------------------------------------------------------------
// Crosshair projection locator queue
// Short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = cpl_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      rd_data,
    output logic                   empty
);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* sv/cpl_back.sv */
// ----------------------------------------------------------------------------
// Crosshair projection locator back end
// Column count memory, row counter, running peaks and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_back #(
    parameter int MAX_WIDTH  = cpl_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = cpl_pkg::MAX_HEIGHT_DEFAULT,
    localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         restart,
    // From the queue.
    input  wire logic                         q_empty,
    input  wire cpl_pkg::flags_t              q_flags,
    input  wire logic [XW-1:0]                q_x,
    input  wire logic [YW-1:0]                q_y,
    output logic                              q_pop,
    // Result output.
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              found,
    output logic [cpl_pkg::INDEX_W-1:0]       best_column,
    output logic [cpl_pkg::INDEX_W-1:0]       best_row
);

    localparam int CW = cpl_pkg::COUNT_W;
    localparam int OW = cpl_pkg::INDEX_W;

    // Column count memory and its registered read data.
    logic [CW-1:0]   col_mem [MAX_WIDTH];
    logic [CW-1:0]   rdata_reg;

    // Update stage.
    logic            s1_valid_reg;
    cpl_pkg::flags_t s1_flags_reg;
    logic [XW-1:0]   s1_x_reg;
    logic [YW-1:0]   s1_y_reg;

    // Frame accumulators.
    logic [CW-1:0]   row_count_reg,    row_count_next;
    logic [CW-1:0]   col_peak_val_reg, col_peak_val_next;
    logic [XW-1:0]   col_peak_idx_reg, col_peak_idx_next;
    logic [CW-1:0]   row_peak_val_reg, row_peak_val_next;
    logic [YW-1:0]   row_peak_idx_reg, row_peak_idx_next;

    // Result register.
    logic            out_valid_reg;
    logic            out_found_reg;
    logic [OW-1:0]   out_col_reg;
    logic [OW-1:0]   out_row_reg;

    logic            out_free;
    logic            s1_go;
    logic            s1_free;
    logic [CW-1:0]   col_cnt;
    logic            res_found;

    // Pipeline flow: the update stage waits only when a frame result meets a full output.
    assign out_free = !out_valid_reg || pop;
    assign s1_go    = s1_valid_reg && (!s1_flags_reg.frame_end || out_free);
    assign s1_free  = !s1_valid_reg || s1_go;
    assign q_pop    = !q_empty && s1_free;

    // New column count; the first row of a frame starts from zero.
    assign col_cnt = (s1_flags_reg.first_row ? '0 : rdata_reg) + CW'(s1_flags_reg.hit);

    // Running counts and peaks after this pixel.
    always_comb
    begin
        row_count_next    = (s1_flags_reg.first_col ? '0 : row_count_reg)
                            + CW'(s1_flags_reg.hit);
        col_peak_val_next = col_peak_val_reg;
        col_peak_idx_next = col_peak_idx_reg;
        row_peak_val_next = row_peak_val_reg;
        row_peak_idx_next = row_peak_idx_reg;
        if (s1_flags_reg.hit)
        begin
            if ((col_cnt > col_peak_val_reg) ||
                ((col_cnt == col_peak_val_reg) && (s1_x_reg < col_peak_idx_reg)))
            begin
                col_peak_val_next = col_cnt;
                col_peak_idx_next = s1_x_reg;
            end
            if (row_count_next > row_peak_val_reg)
            begin
                row_peak_val_next = row_count_next;
                row_peak_idx_next = s1_y_reg;
            end
        end
    end

    assign res_found = (col_peak_val_next != '0) && (row_peak_val_next != '0);

    // Memory write from the update stage, read for the item entering it.
    always_ff @(posedge clk)
    begin
        if (s1_go)
            col_mem[s1_x_reg] <= col_cnt;
        if (q_pop)
        begin
            if (s1_go && (s1_x_reg == q_x))
                rdata_reg <= col_cnt;
            else
                rdata_reg <= col_mem[q_x];
        end
    end

    // Update stage payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_flags_reg <= q_flags;
            s1_x_reg     <= q_x;
            s1_y_reg     <= q_y;
        end
    end

    // Control, accumulators and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            row_count_reg    <= '0;
            col_peak_val_reg <= '0;
            col_peak_idx_reg <= '0;
            row_peak_val_reg <= '0;
            row_peak_idx_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_found_reg    <= 1'b0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= q_pop;

            if (restart)
            begin
                row_count_reg    <= '0;
                col_peak_val_reg <= '0;
                col_peak_idx_reg <= '0;
                row_peak_val_reg <= '0;
                row_peak_idx_reg <= '0;
            end
            else if (s1_go)
            begin
                if (s1_flags_reg.frame_end)
                begin
                    row_count_reg    <= '0;
                    col_peak_val_reg <= '0;
                    col_peak_idx_reg <= '0;
                    row_peak_val_reg <= '0;
                    row_peak_idx_reg <= '0;
                end
                else
                begin
                    row_count_reg    <= row_count_next;
                    col_peak_val_reg <= col_peak_val_next;
                    col_peak_idx_reg <= col_peak_idx_next;
                    row_peak_val_reg <= row_peak_val_next;
                    row_peak_idx_reg <= row_peak_idx_next;
                end
            end

            // A frame's last pixel loads the result; a pop frees it.
            if (s1_go && s1_flags_reg.frame_end)
            begin
                out_valid_reg <= 1'b1;
                out_found_reg <= res_found;
                out_col_reg   <= res_found ? OW'(col_peak_idx_next) : '0;
                out_row_reg   <= res_found ? OW'(row_peak_idx_next) : '0;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign found       = out_found_reg;
    assign best_column = out_col_reg;
    assign best_row    = out_row_reg;

endmodule

`default_nettype wire

/* sv/crosshair_projection_locator.sv */
// ----------------------------------------------------------------------------
// Crosshair projection locator
// Finds the column and row of a frame holding the most marker-colored pixels.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   -------   ----------------   -----------------------------------
//   input     push / full        pixel (8 bits)
//   result    empty / pop        found, best_column, best_row
//   config    wr_en              wr_index (2 bits), wr_data (11 bits)
//
// One pixel is accepted every cycle while full is low; the column count memory
// does one read and one write per cycle, with the write forwarded to a read of
// the same column. A frame's result passes the queue, the update stage and the
// result register. Reset clears positions, counters and peaks; the column
// memory needs no clearing because the first row of a frame writes it.
// A result still waiting in the output register holds the next frame's last
// pixel in the update stage; the queue then fills and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module crosshair_projection_locator #(
    parameter int MAX_WIDTH  = cpl_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = cpl_pkg::MAX_HEIGHT_DEFAULT,
    localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [cpl_pkg::REG_INDEX_W-1:0]  wr_index,
    input  wire logic [cpl_pkg::DIM_W-1:0]        wr_data,
    input  wire logic                             push,
    input  wire logic [cpl_pkg::PIXEL_W-1:0]      pixel,
    output logic                                  full,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic                                  found,
    output logic [cpl_pkg::INDEX_W-1:0]           best_column,
    output logic [cpl_pkg::INDEX_W-1:0]           best_row
);

    localparam int QW = cpl_pkg::FLAGS_W + XW + YW;

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    logic            restart;
    cpl_pkg::flags_t f_flags;
    logic [XW-1:0]   f_x;
    logic [YW-1:0]   f_y;
    cpl_pkg::flags_t b_flags;
    logic [XW-1:0]   b_x;
    logic [YW-1:0]   b_y;
    logic [QW-1:0]   q_wr_data;
    logic [QW-1:0]   q_rd_data;

    // Front end: configuration, position and classification.
    cpl_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .pixel    (pixel),
        .full     (full),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_flags  (f_flags),
        .q_x      (f_x),
        .q_y      (f_y),
        .restart  (restart)
    );

    // Queue between the two ends.
    assign q_wr_data          = {f_flags, f_x, f_y};
    assign {b_flags, b_x, b_y} = q_rd_data;

    cpl_queue #(
        .DATA_W (QW),
        .DEPTH  (cpl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Back end: counting, peaks and result.
    cpl_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .q_empty     (q_empty),
        .q_flags     (b_flags),
        .q_x         (b_x),
        .q_y         (b_y),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .found       (found),
        .best_column (best_column),
        .best_row    (best_row)
    );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Crosshair projection locator testbench
// Streams frames of pixels through the locator with random gaps on both
// sides and checks every reported column and row against a predictor that
// follows the block pixel by pixel.
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cpl_pkg::*;

    // Index past the end of the register list; writes to it are ignored.
    localparam logic [REG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int          MAX_DIM        = 1024;
    localparam int unsigned RANDOM_PIXELS  = 300;
    localparam int unsigned HOLD_CYCLES    = 600;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] column;
        logic [INDEX_W-1:0] row;
    } peak_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               wr_en    = 1'b0;
    logic [REG_INDEX_W-1:0] wr_index = '0;
    logic [DIM_W-1:0]   wr_data  = '0;
    logic               push     = 1'b0;
    logic [PIXEL_W-1:0] pixel    = '0;
    logic               pop      = 1'b0;
    logic               full;
    logic               empty;
    logic               found;
    logic [INDEX_W-1:0] best_column;
    logic [INDEX_W-1:0] best_row;

    crosshair_projection_locator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .push        (push),
        .pixel       (pixel),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .found       (found),
        .best_column (best_column),
        .best_row    (best_row)
    );

    // Clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor copy of the registers and of the frame state.
    logic [PIXEL_W-1:0] marker;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COUNT_W-1:0] col_tally [0:MAX_DIM-1];
    logic [COUNT_W-1:0] row_tally;
    int unsigned        xpos;
    int unsigned        ypos;
    logic [COUNT_W-1:0] col_peak;
    logic [INDEX_W-1:0] col_peak_at;
    logic [COUNT_W-1:0] row_peak;
    logic [INDEX_W-1:0] row_peak_at;

    logic [PIXEL_W-1:0] pixel_q [$];
    peak_t              peak_q [$];
    int unsigned        queued   = 0;
    int unsigned        accepted = 0;
    int unsigned        peaks_seen = 0;
    int unsigned        errors   = 0;
    int unsigned        cycles   = 0;

    // A geometry register of 0 acts as 1, and anything past the maximum as the maximum.
    function automatic int unsigned span(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic void clear_frame();
        row_tally   = '0;
        xpos        = 0;
        ypos        = 0;
        col_peak    = '0;
        col_peak_at = '0;
        row_peak    = '0;
        row_peak_at = '0;
    endfunction

    // Advance the frame by one accepted pixel; the last pixel of a frame
    // leaves the expected peak position in the queue.
    function automatic void project_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned        w;
        int unsigned        h;
        logic               hit;
        logic [COUNT_W-1:0] tally;
        peak_t              res;
        w   = span(width_reg);
        h   = span(height_reg);
        hit = (px == marker);

        // The first row of a frame starts every column count afresh.
        tally = (ypos == 0) ? '0 : col_tally[xpos];
        tally = tally + COUNT_W'(hit);
        col_tally[xpos] = tally;
        if (hit && (tally > col_peak || (tally == col_peak && xpos < col_peak_at)))
        begin
            col_peak    = tally;
            col_peak_at = INDEX_W'(xpos);
        end

        // Row counts only need the current row; the earliest row keeps a tie.
        if (xpos == 0)
            row_tally = '0;
        if (hit)
        begin
            row_tally = row_tally + 1'b1;
            if (row_tally > row_peak)
            begin
                row_peak    = row_tally;
                row_peak_at = INDEX_W'(ypos);
            end
        end

        if (xpos + 1 < w)
            xpos++;
        else
        begin
            xpos = 0;
            if (ypos + 1 < h)
                ypos++;
            else
            begin
                res.found  = (col_peak != 0) && (row_peak != 0);
                res.column = res.found ? col_peak_at : '0;
                res.row    = res.found ? row_peak_at : '0;
                peak_q.push_back(res);
                clear_frame();
            end
        end
    endfunction

    // Idle cycles before the next item, with occasional stretches of none.
    function automatic int unsigned draw_idle(inout int unsigned calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [PIXEL_W-1:0] non_marker();
        logic [PIXEL_W-1:0] v;
        v = PIXEL_W'($urandom_range(0, 255));
        if (v == marker)
            v = v ^ 8'h01;
        return v;
    endfunction

    function automatic void queue_pixel(input logic [PIXEL_W-1:0] px);
        pixel_q.push_back(px);
        queued++;
    endfunction

    // A frame with an optional marker column at cx and marker row at cy
    // (an index equal to the size draws no line) over random speckle.
    function automatic void add_frame(input int unsigned w, input int unsigned h,
                                      input int unsigned cx, input int unsigned cy,
                                      input int unsigned density);
        for (int unsigned y = 0; y < h; y++)
            for (int unsigned x = 0; x < w; x++)
                if (x == cx || y == cy || $urandom_range(0, 99) < density)
                    queue_pixel(marker);
                else
                    queue_pixel(non_marker());
    endfunction

    task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 1'b0;
        case (idx)
            REG_MARKER_COLOR:
                marker = data[PIXEL_W-1:0];
            REG_FRAME_WIDTH:
            begin
                width_reg = data;
                clear_frame();
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg = data;
                clear_frame();
            end
            default: ;
        endcase
    endtask

    // Block until every queued item is taken, every peak is back, and the
    // pipeline has had time to drain.
    task automatic wait_idle();
        while (accepted != queued || peak_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel driver.
    int unsigned src_idle = 0;
    int unsigned src_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push  <= 1'b0;
            pixel <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                project_pixel(pixel);
                accepted++;
            end
            if (push && full)
            begin
                // Stalled item stays on the port.
            end
            else if (src_idle > 0)
            begin
                src_idle--;
                push <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                pixel    <= pixel_q.pop_front();
                push     <= 1'b1;
                src_idle = draw_idle(src_calm);
            end
            else
                push <= 1'b0;
        end
    end

    // Result monitor, with two long hold-offs to back the block up.
    int unsigned sink_idle = 0;
    int unsigned sink_calm = 0;
    int unsigned sink_hold = 0;

    always @(posedge clk or negedge rst_n)
    begin
        peak_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (peak_q.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0d column=%0d row=%0d",
                             $realtime, found, best_column, best_row);
                    errors++;
                end
                else
                begin
                    want = peak_q.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d",
                                 $realtime, want.found, found);
                        errors++;
                    end
                    if (best_column !== want.column)
                    begin
                        $display("%0t: best_column expected %0d actual %0d",
                                 $realtime, want.column, best_column);
                        errors++;
                    end
                    if (best_row !== want.row)
                    begin
                        $display("%0t: best_row expected %0d actual %0d",
                                 $realtime, want.row, best_row);
                        errors++;
                    end
                end
                peaks_seen++;
                if (peaks_seen == 2 || peaks_seen == 45)
                    sink_hold = HOLD_CYCLES;
                sink_idle = draw_idle(sink_calm);
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                pop <= 1'b0;
            end
            else if (sink_idle > 0)
            begin
                sink_idle--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus: directed frames, random small frames, then the widest frame.
    initial
    begin
        logic [8:0]  masks [0:1];
        int unsigned w;
        int unsigned h;
        int unsigned frames;

        marker     = '0;
        width_reg  = DIM_W'(DIM_RESET);
        height_reg = DIM_W'(DIM_RESET);
        clear_frame();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // One-pixel frames: zero geometry acts as 1, and both marker extremes.
        write_reg(REG_MARKER_COLOR, '0);
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        write_reg(REG_UNUSED, 11'h7FF);
        queue_pixel(8'h00);
        queue_pixel(8'hFF);
        wait_idle();

        // The receiver holds off after the second result, so this run of
        // one-pixel frames fills the result register and the queue.
        write_reg(REG_MARKER_COLOR, 11'h0FF);
        for (int i = 0; i < 8; i++)
            queue_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
        wait_idle();

        // 3x3 frames: a column tie settled by the lower index, then a late peak.
        masks[0] = 9'b101_011_100;
        masks[1] = 9'b000_001_011;
        write_reg(REG_MARKER_COLOR, 11'h0A5);
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < 9; i++)
                queue_pixel(masks[k][8-i] ? marker : non_marker());

        // Random phases of small crosshair frames.
        while (queued < RANDOM_PIXELS)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       write_reg(REG_MARKER_COLOR, {3'($urandom), 8'h00});
                1:       write_reg(REG_MARKER_COLOR, {3'($urandom), 8'hFF});
                default: write_reg(REG_MARKER_COLOR, DIM_W'($urandom));
            endcase
            write_reg(REG_FRAME_WIDTH,
                      ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 8)));
            write_reg(REG_FRAME_HEIGHT,
                      ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 8)));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, DIM_W'($urandom));
            w      = span(width_reg);
            h      = span(height_reg);
            frames = $urandom_range(2, 4);
            for (int f = 0; f < frames; f++)
                if ($urandom_range(0, 4) == 0)
                    add_frame(w, h, w, h, $urandom_range(0, 60));
                else
                    add_frame(w, h, $urandom_range(0, w), $urandom_range(0, h),
                              $urandom_range(0, 30));
        end

        // Widest frame, with an oversized width register: peak in the last column.
        wait_idle();
        write_reg(REG_MARKER_COLOR, 11'h0FF);
        write_reg(REG_FRAME_WIDTH, 11'h7FF);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        add_frame(MAX_DIM, 1, MAX_DIM - 1, 1, 0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && peak_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
